[rtl/core/upe_pkg.sv]
package upe_pkg;

    localparam int unsigned CHAR_W  = 16;
    localparam int unsigned SPACE_W = 20;
    localparam int unsigned IDX_W   = 3;

    localparam logic [SPACE_W-1:0] CAP_RESET = 20'hFFFFF;

    localparam logic [7:0] ASCII_PCT = 8'h25;
    localparam logic [7:0] ASCII_U   = 8'h75;

    typedef enum logic [1:0] {
        FORM_RAW  = 2'd0,
        FORM_PCT  = 2'd1,
        FORM_WIDE = 2'd2
    } t_form;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        t_form             form;
    } t_job;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } t_sym;

    function automatic logic [7:0] upe_hex(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = 8'h30 + {4'd0, v};
        end else begin
            r = 8'h37 + {4'd0, v};
        end
        return r;
    endfunction

    function automatic t_sym upe_byte(input logic [CHAR_W-1:0] code, input t_form form,
                                      input logic [IDX_W-1:0] idx);
        t_sym s;
        s.last = 1'b0;
        s.data = ASCII_PCT;
        case (form)
            FORM_RAW: begin
                s.data = code[7:0];
                s.last = 1'b1;
            end
            FORM_PCT: begin
                case (idx)
                    3'd0:    s.data = ASCII_PCT;
                    3'd1:    s.data = upe_hex(code[7:4]);
                    default: begin
                        s.data = upe_hex(code[3:0]);
                        s.last = 1'b1;
                    end
                endcase
            end
            default: begin
                case (idx)
                    3'd0:    s.data = ASCII_PCT;
                    3'd1:    s.data = ASCII_U;
                    3'd2:    s.data = upe_hex(code[15:12]);
                    3'd3:    s.data = upe_hex(code[11:8]);
                    3'd4:    s.data = upe_hex(code[7:4]);
                    default: begin
                        s.data = upe_hex(code[3:0]);
                        s.last = 1'b1;
                    end
                endcase
            end
        endcase
        return s;
    endfunction

endpackage

[rtl/core/upe_front.sv]
module upe_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [upe_pkg::SPACE_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [upe_pkg::CHAR_W-1:0]  i_char_code,
    input  logic                        i_pass_through,
    input  logic                        i_restart,
    input  logic                        i_q_full,
    output logic                        o_push,
    output upe_pkg::t_job               o_job
);
    import upe_pkg::*;

    logic [SPACE_W-1:0] r_capacity;
    logic [SPACE_W-1:0] r_space;
    logic [SPACE_W-1:0] n_space;
    logic [SPACE_W-1:0] space_eff;
    logic               unres;
    logic               accept;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign space_eff  = i_restart ? r_capacity : r_space;

    always_comb begin
        unres = (i_char_code inside {[16'h41:16'h5A], [16'h61:16'h7A], [16'h30:16'h39],
                                     16'h2D, 16'h5F, 16'h2E, 16'h7E});
        o_job.code = i_char_code;
        o_job.form = FORM_RAW;
        o_push     = 1'b0;
        n_space    = space_eff;
        if ((unres || i_pass_through) && space_eff > 20'd1) begin
            o_job.form = FORM_RAW;
            o_push     = accept;
            n_space    = space_eff - 20'd1;
        end else if (i_char_code < 16'd256 && space_eff > 20'd3) begin
            o_job.form = FORM_PCT;
            o_push     = accept;
            n_space    = space_eff - 20'd3;
        end else if (space_eff > 20'd6) begin
            o_job.form = FORM_WIDE;
            o_push     = accept;
            n_space    = space_eff - 20'd6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
            r_space    <= CAP_RESET;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            if (accept) begin
                r_space <= n_space;
            end
        end
    end

endmodule

[rtl/core/upe_queue.sv]
module upe_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  upe_pkg::t_job i_job,
    input  logic          i_pop,
    output upe_pkg::t_job o_head,
    output logic          o_empty,
    output logic          o_full
);
    import upe_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

[rtl/core/upe_back.sv]
module upe_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  upe_pkg::t_job i_head,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [7:0]    o_out_byte,
    output logic          o_run_end
);
    import upe_pkg::*;

    logic             r_busy;
    t_job             r_job;
    logic [IDX_W-1:0] r_idx;
    logic             r_ovalid;
    logic [7:0]       r_byte;
    logic             r_end;

    logic             load_ok;
    logic             take;
    t_job             src;
    logic [IDX_W-1:0] idx;
    t_sym             sym;

    assign load_ok = !r_ovalid || i_out_ready;
    assign take    = load_ok && (r_busy || !i_empty);
    assign o_pop   = load_ok && !r_busy && !i_empty;
    assign src     = r_busy ? r_job : i_head;
    assign idx     = r_busy ? r_idx : '0;
    assign sym     = upe_byte(src.code, src.form, idx);

    assign o_out_valid = r_ovalid;
    assign o_out_byte  = r_byte;
    assign o_run_end   = r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (take) begin
                r_ovalid <= 1'b1;
                r_busy   <= !sym.last;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte <= sym.data;
            r_end  <= sym.last;
            r_idx  <= idx + 1'b1;
            if (!r_busy) begin
                r_job <= i_head;
            end
        end
    end

endmodule

[rtl/core/url_percent_encoder.sv]
// URL percent encoder. Each request carries one 16-bit character and yields one byte
// (unreserved or pass-through), "%XX" (codes below 256) or "%uXXXX", with uppercase
// hex, or nothing when the remaining space (reloaded from capacity on restart) is too
// small. The front takes one request per cycle while the job queue has room; the back
// drives one output byte per cycle while i_out_ready allows, so a character yields 1,
// 3 or 6 bytes and a dropped one is not queued. Output throughput is bounded by the
// byte-wide output register; the queue absorbs short stalls on either side.
module url_percent_encoder #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [upe_pkg::SPACE_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [upe_pkg::CHAR_W-1:0]  i_char_code,
    input  logic                        i_pass_through,
    input  logic                        i_restart,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [7:0]                  o_out_byte,
    output logic                        o_run_end
);
    import upe_pkg::*;

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_job job_in;
    t_job job_head;

    upe_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_char_code    (i_char_code),
        .i_pass_through (i_pass_through),
        .i_restart      (i_restart),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_job          (job_in)
    );

    upe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_head  (job_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    upe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (job_head),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_run_end   (o_run_end)
    );

endmodule
